FILE: rtl/emacc_pkg.sv
// ----------------------------------------------------------------------------
// Energy meter accumulator package
// Shared constants, register indexes and the types that pass between the
// serial arithmetic units and the sequencer.
// ----------------------------------------------------------------------------
package emacc_pkg;

  localparam int NUM_CH      = 3;
  localparam int CH_W        = 2;
  localparam int SAMPLE_BITS = 10;

  localparam int ACC_W   = 32;
  localparam int MUL_W   = 16;
  localparam int PROD_W  = 2 * MUL_W;
  localparam int CONST_W = 16;
  localparam int PULSE_W = 8;
  localparam int ROUND_W = 16;
  localparam int POWER_W = 21;
  localparam int BASE_W  = 20;

  localparam logic [CH_W-1:0] CH_LAST = CH_W'(NUM_CH - 1);

  // Power scaling: p = 3600 W per pulse plus or minus ((|rest| >> 16) * 61909) >> 18.
  localparam logic [MUL_W-1:0] POWER_SCALE    = 16'd61909;
  localparam int               POWER_SHIFT    = 18;
  localparam int               REST_SHIFT     = 16;
  localparam int               P_W            = PROD_W - POWER_SHIFT;
  localparam logic [11:0]      WATT_PER_PULSE = 12'd3600;

  // Configuration register indexes.
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] CFG_MCONST0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MCONST1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MCONST2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_QUANTUM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PERIOD  = 3'd5;

  localparam logic [ACC_W-1:0]   QUANTUM_RST = 32'd1000000000;
  localparam logic [ROUND_W-1:0] PERIOD_RST  = 16'd666;

  // Result item layout in out_tdata.
  localparam int OUT_DATA_W = 56;

  // Operation of the serial add/subtract unit.
  typedef struct packed {
    logic sub_b;   // x = a - b instead of a + b
    logic swap_y;  // y = c - x instead of x - c
  } sadd_op_t;

  // Result of one serial pass.
  typedef struct packed {
    logic [ACC_W-1:0] x;
    logic [ACC_W-1:0] y;
    logic             no_borrow;  // y's subtraction did not borrow out
    logic             y_nz;       // y is not zero
  } sadd_res_t;

endpackage

FILE: rtl/emacc_mul.sv
// ----------------------------------------------------------------------------
// Serial shift-add multiplier
// Unsigned 16 x 16 multiply, one multiplier bit retired per clock cycle.
// ----------------------------------------------------------------------------
module emacc_mul import emacc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [MUL_W-1:0]  mcand,
  input  logic [MUL_W-1:0]  mplier,
  output logic              done,
  output logic [PROD_W-1:0] prod
);

  logic             run_r;
  logic             done_r;
  logic [3:0]       cnt_r;
  logic [MUL_W-1:0] mcand_r;
  logic [MUL_W-1:0] hi_r;
  logic [MUL_W-1:0] lo_r;
  logic [MUL_W-1:0] addend;
  logic [MUL_W:0]   sum;

  assign addend = lo_r[0] ? mcand_r : '0;
  assign sum    = {1'b0, hi_r} + {1'b0, addend};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 4'd1;
        if (cnt_r == 4'd15) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // The low half starts as the multiplier and fills with product bits.
  always_ff @(posedge clk) begin
    if (start) begin
      mcand_r <= mcand;
      hi_r    <= '0;
      lo_r    <= mplier;
    end else if (run_r) begin
      hi_r <= sum[MUL_W:1];
      lo_r <= {sum[0], lo_r[MUL_W-1:1]};
    end
  end

  assign done = done_r;
  assign prod = {hi_r, lo_r};

endmodule

FILE: rtl/emacc_sadd.sv
// ----------------------------------------------------------------------------
// Bit-serial add/subtract unit
// Forms x = a +/- b and then y = x - c or c - x, one bit per cycle, LSB first.
// ----------------------------------------------------------------------------
module emacc_sadd import emacc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [ACC_W-1:0] a,
  input  logic [ACC_W-1:0] b,
  input  logic [ACC_W-1:0] c,
  input  sadd_op_t         op,
  output logic             done,
  output sadd_res_t        res
);

  logic             run_r;
  logic             done_r;
  logic [4:0]       cnt_r;
  sadd_op_t         op_r;
  logic [ACC_W-1:0] a_r;
  logic [ACC_W-1:0] b_r;
  logic [ACC_W-1:0] c_r;
  logic [ACC_W-1:0] x_r;
  logic [ACC_W-1:0] y_r;
  logic             cx_r;
  logic             by_r;
  logic             nz_r;
  logic             bb;
  logic             xb;
  logic             cx_nxt;
  logic             pb;
  logic             qb;
  logic             yb;
  logic             by_nxt;

  always_comb begin
    bb     = b_r[0] ^ op_r.sub_b;
    xb     = a_r[0] ^ bb ^ cx_r;
    cx_nxt = (a_r[0] & bb) | (cx_r & (a_r[0] ^ bb));
    pb     = op_r.swap_y ? c_r[0] : xb;
    qb     = op_r.swap_y ? xb : c_r[0];
    yb     = pb ^ qb ^ by_r;
    by_nxt = (~pb & qb) | (~(pb ^ qb) & by_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op_r <= op;
      a_r  <= a;
      b_r  <= b;
      c_r  <= c;
      cx_r <= op.sub_b;
      by_r <= 1'b0;
      nz_r <= 1'b0;
    end else if (run_r) begin
      a_r  <= {1'b0, a_r[ACC_W-1:1]};
      b_r  <= {1'b0, b_r[ACC_W-1:1]};
      c_r  <= {1'b0, c_r[ACC_W-1:1]};
      x_r  <= {xb, x_r[ACC_W-1:1]};
      y_r  <= {yb, y_r[ACC_W-1:1]};
      cx_r <= cx_nxt;
      by_r <= by_nxt;
      nz_r <= nz_r | yb;
    end
  end

  assign done          = done_r;
  assign res.x         = x_r;
  assign res.y         = y_r;
  assign res.no_borrow = ~by_r;
  assign res.y_nz      = nz_r;

endmodule

FILE: rtl/energy_meter_accumulator.sv
// ----------------------------------------------------------------------------
// Energy meter accumulator
// Three-channel energy metering of ADC samples with windowed power output.
// ----------------------------------------------------------------------------
//
//   Channel | Direction | Handshake             | Contents
//   --------+-----------+-----------------------+-------------------------------
//   in_     | input     | in_tvalid / in_tready | one ADC sample item
//   out_    | output    | out_tvalid/out_tready | one result item per sample
//   cfg_    | input     | cfg_we                | register write, no read-back
//
// An item on a disabled channel skips the arithmetic. On an enabled channel
// the product constant * sample is formed in the shift-add multiplier, and
// the accumulator update and quantum compare then run in the bit-serial
// adder. At the end of a window a second serial pass and a second multiply
// form the power. Reset is synchronous and active low; it clears all
// channel state and loads the register defaults. A new item is accepted
// while the previous result still waits on out_tready; its result waits in
// turn until the output register is free.
//
module energy_meter_accumulator import emacc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  // in_tdata: sample [9:0], zeros above
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [15:0]           in_tdata,
  // out_tdata: channel [1:0], pulse [2], energy_count [34:3],
  //            power_watts [55:35]
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,
  // out_tuser: power_valid [0]
  output logic                  out_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [ACC_W-1:0]      cfg_wdata
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_POW  = 3'd3;
  localparam logic [2:0] S_PMUL = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  // Configuration registers.
  logic [CONST_W-1:0] mconst_r [NUM_CH];
  logic [NUM_CH-1:0]  en_r;
  logic [ACC_W-1:0]   quantum_r;
  logic [ROUND_W-1:0] period_r;

  // Per-channel metering state. The start of a window is implied by the
  // previous end, so only the window end is kept.
  logic [ACC_W-1:0]   accum_r  [NUM_CH];
  logic [ACC_W-1:0]   units_r  [NUM_CH];
  logic [PULSE_W-1:0] wpulse_r [NUM_CH];
  logic [PULSE_W-1:0] lpulse_r [NUM_CH];
  logic [ACC_W-1:0]   aend_r   [NUM_CH];
  logic [NUM_CH-1:0]  lock_r;

  logic [2:0]         state_r;
  logic [CH_W-1:0]    chan_r;
  logic [ROUND_W-1:0] round_r;
  logic               lock_eff_r;
  logic               pulse_r;
  logic               pvalid_r;
  logic               neg_r;
  logic [BASE_W-1:0]  base_r;
  logic [POWER_W-1:0] power_r;

  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_user_r;

  // Serial units.
  logic              mul_start;
  logic [MUL_W-1:0]  mul_a;
  logic [MUL_W-1:0]  mul_b;
  logic              mul_done;
  logic [PROD_W-1:0] mul_prod;
  logic              sadd_start;
  logic [ACC_W-1:0]  sadd_a;
  logic [ACC_W-1:0]  sadd_b;
  logic [ACC_W-1:0]  sadd_c;
  sadd_op_t          sadd_op;
  logic              sadd_done;
  sadd_res_t         sadd_res;

  logic               in_acc;
  logic               ch_en;
  logic               gt;
  logic [ACC_W-1:0]   acc_new;
  logic [PULSE_W-1:0] wp_new;
  logic               do_latch;
  logic [ACC_W-1:0]   mag;
  logic               out_free;
  logic [CH_W-1:0]    chan_nxt;
  logic [ROUND_W-1:0] round_inc;
  logic [POWER_W-1:0] power_nxt;

  assign in_tready = (state_r == S_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign ch_en     = en_r[chan_r];
  assign out_free  = !out_valid_r || out_tready;

  // Accumulator compare: the sum exceeds the quantum when sum - quantum
  // neither borrows nor is zero. With a zero quantum y equals x.
  assign gt       = sadd_res.no_borrow && sadd_res.y_nz;
  assign acc_new  = gt ? sadd_res.y : sadd_res.x;
  assign wp_new   = gt ? wpulse_r[chan_r] + PULSE_W'(1) : wpulse_r[chan_r];
  assign do_latch = (round_r == period_r) && !lock_eff_r;

  // Power pass leaves x = end_old - end_new and y = end_new - end_old.
  assign mag = sadd_res.y[ACC_W-1] ? sadd_res.x : sadd_res.y;

  assign power_nxt = neg_r
      ? POWER_W'({1'b0, base_r} - {{(POWER_W - P_W){1'b0}}, mul_prod[PROD_W-1:POWER_SHIFT]})
      : POWER_W'({1'b0, base_r} + {{(POWER_W - P_W){1'b0}}, mul_prod[PROD_W-1:POWER_SHIFT]});

  assign chan_nxt  = (chan_r == CH_LAST) ? '0 : chan_r + CH_W'(1);
  assign round_inc = (chan_nxt == '0) ? round_r + ROUND_W'(1) : round_r;

  always_comb begin
    mul_start  = 1'b0;
    mul_a      = mconst_r[chan_r];
    mul_b      = {{(MUL_W - SAMPLE_BITS){1'b0}}, in_tdata[SAMPLE_BITS-1:0]};
    sadd_start = 1'b0;
    sadd_a     = accum_r[chan_r];
    sadd_b     = mul_prod;
    sadd_c     = quantum_r;
    sadd_op    = '{sub_b: 1'b0, swap_y: 1'b0};
    case (state_r)
      S_IDLE: begin
        mul_start = in_acc && ch_en;
      end
      S_MUL: begin
        sadd_start = mul_done;
      end
      S_ADD: begin
        sadd_start = sadd_done && do_latch;
        sadd_a     = aend_r[chan_r];
        sadd_b     = acc_new;
        sadd_c     = '0;
        sadd_op    = '{sub_b: 1'b1, swap_y: 1'b1};
      end
      S_POW: begin
        mul_start = sadd_done;
        mul_a     = POWER_SCALE;
        mul_b     = mag[ACC_W-1:REST_SHIFT];
      end
      default: begin
      end
    endcase
  end

  emacc_mul u_mul (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (mul_start),
    .mcand  (mul_a),
    .mplier (mul_b),
    .done   (mul_done),
    .prod   (mul_prod)
  );

  emacc_sadd u_sadd (
    .clk   (clk),
    .rst_n (rst_n),
    .start (sadd_start),
    .a     (sadd_a),
    .b     (sadd_b),
    .c     (sadd_c),
    .op    (sadd_op),
    .done  (sadd_done),
    .res   (sadd_res)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CH; i++) begin
        mconst_r[i] <= '0;
      end
      en_r      <= '0;
      quantum_r <= QUANTUM_RST;
      period_r  <= PERIOD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MCONST0: mconst_r[0] <= cfg_wdata[CONST_W-1:0];
        CFG_MCONST1: mconst_r[1] <= cfg_wdata[CONST_W-1:0];
        CFG_MCONST2: mconst_r[2] <= cfg_wdata[CONST_W-1:0];
        CFG_ENABLE:  en_r        <= cfg_wdata[NUM_CH-1:0];
        CFG_QUANTUM: quantum_r   <= cfg_wdata;
        CFG_PERIOD:  period_r    <= cfg_wdata[ROUND_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer and channel state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chan_r      <= '0;
      round_r     <= '0;
      lock_r      <= '0;
      lock_eff_r  <= 1'b0;
      pulse_r     <= 1'b0;
      pvalid_r    <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_CH; i++) begin
        accum_r[i]  <= '0;
        units_r[i]  <= '0;
        wpulse_r[i] <= '0;
        lpulse_r[i] <= '0;
        aend_r[i]   <= '0;
      end
    end else begin
      // The output register refills on the edge that empties it.
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && out_tready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            pulse_r  <= 1'b0;
            pvalid_r <= 1'b0;
            if (ch_en) begin
              // Round zero releases the channel's latch lock.
              if (round_r == '0) begin
                lock_r[chan_r] <= 1'b0;
                lock_eff_r     <= 1'b0;
              end else begin
                lock_eff_r     <= lock_r[chan_r];
              end
              state_r <= S_MUL;
            end else begin
              state_r <= S_DONE;
            end
          end
        end
        S_MUL: begin
          if (mul_done) begin
            state_r <= S_ADD;
          end
        end
        S_ADD: begin
          if (sadd_done) begin
            accum_r[chan_r] <= acc_new;
            pulse_r         <= gt;
            if (gt) begin
              units_r[chan_r] <= units_r[chan_r] + ACC_W'(1);
            end
            if (do_latch) begin
              aend_r[chan_r]   <= acc_new;
              lpulse_r[chan_r] <= wp_new;
              wpulse_r[chan_r] <= '0;
              lock_r[chan_r]   <= 1'b1;
              pvalid_r         <= 1'b1;
              state_r          <= S_POW;
            end else begin
              wpulse_r[chan_r] <= wp_new;
              state_r          <= S_DONE;
            end
          end
        end
        S_POW: begin
          if (sadd_done) begin
            state_r <= S_PMUL;
          end
        end
        S_PMUL: begin
          if (mul_done) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            chan_r      <= chan_nxt;
            // A round beyond the period, also after the period was lowered,
            // starts over at zero.
            round_r     <= (round_inc > period_r) ? '0 : round_inc;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // Power datapath and output payload.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      power_r <= '0;
    end
    if (state_r == S_POW && sadd_done) begin
      neg_r  <= sadd_res.y[ACC_W-1];
      base_r <= BASE_W'(lpulse_r[chan_r]) * BASE_W'(WATT_PER_PULSE);
    end
    if (state_r == S_PMUL && mul_done) begin
      power_r <= power_nxt;
    end
    if (state_r == S_DONE && out_free) begin
      out_data_r <= {power_r, units_r[chan_r], pulse_r, chan_r};
      out_user_r <= pvalid_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

  // The channel index never leaves the range of existing channels.
  a_chan_range: assert property (@(posedge clk) disable iff (!rst_n)
    chan_r <= CH_LAST)
    else $error("channel index out of range");

  // Without a new power value the power field reads zero.
  a_power_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_user_r) |-> (out_data_r[OUT_DATA_W-1:35] == '0))
    else $error("power field not zero without power_valid");

  // Pulses and power values only come from enabled channels.
  a_enabled_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r[2] || out_user_r)) |-> en_r[out_data_r[1:0]])
    else $error("pulse or power on a disabled channel");

  // The two serial units are never finishing at the same time.
  a_units_apart: assert property (@(posedge clk) disable iff (!rst_n)
    !(mul_done && sadd_done))
    else $error("multiplier and serial adder done together");

endmodule

FILE: sim/energy_meter_accumulator_check.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Energy meter accumulator result checker
// Watches the sample, result and register ports, keeps a shadow of the
// meter state, predicts each result item and compares it field by field.
// ----------------------------------------------------------------------------
module energy_meter_accumulator_check import emacc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [15:0]           in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  out_tuser,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [ACC_W-1:0]      cfg_wdata,
  output int                    errors,
  output int                    pending,
  output int                    checked,
  output int                    windows,
  output int                    pulses
);

  typedef struct packed {
    logic [CH_W-1:0]    channel;
    logic               pulse;
    logic [ACC_W-1:0]   energy_count;
    logic               power_valid;
    logic [POWER_W-1:0] power_watts;
  } meter_result_t;

  // Register shadow.
  logic [CONST_W-1:0] weight [NUM_CH];
  logic [NUM_CH-1:0]  enabled;
  logic [ACC_W-1:0]   quantum;
  logic [ROUND_W-1:0] period;

  // Channel state.
  logic [ACC_W-1:0]   accum        [NUM_CH];
  logic [ACC_W-1:0]   units        [NUM_CH];
  logic [PULSE_W-1:0] open_pulses  [NUM_CH];
  logic [PULSE_W-1:0] closed_pulses[NUM_CH];
  logic [ACC_W-1:0]   prev_mark    [NUM_CH];
  logic [ACC_W-1:0]   last_mark    [NUM_CH];
  logic               latched      [NUM_CH];
  logic [CH_W-1:0]    chan;
  logic [ROUND_W-1:0] round;

  meter_result_t predicted_results[$];
  int            bad_items    = 0;
  int            seen         = 0;
  int            window_count = 0;
  int            pulse_total  = 0;

  // Power of the window that was just closed on channel c. The accumulator
  // residue difference is signed; its magnitude is scaled and then added to
  // or taken from the whole pulses at 3600 W each.
  function automatic logic [POWER_W-1:0] window_watts(input int c);
    logic [ACC_W-1:0]   rest;
    logic [ACC_W-1:0]   mag;
    logic [ACC_W-1:0]   frac;
    logic [POWER_W-1:0] base;
    rest = last_mark[c] - prev_mark[c];
    mag  = rest[ACC_W-1] ? (~rest + 1'b1) : rest;
    frac = ({16'd0, mag[ACC_W-1:REST_SHIFT]} * {16'd0, POWER_SCALE}) >> POWER_SHIFT;
    base = POWER_W'(closed_pulses[c]) * POWER_W'(WATT_PER_PULSE);
    return rest[ACC_W-1] ? base - frac[POWER_W-1:0] : base + frac[POWER_W-1:0];
  endfunction

  function automatic meter_result_t apply_sample(input logic [SAMPLE_BITS-1:0] s);
    meter_result_t r;
    int            c;
    c = int'(chan);
    r = '0;
    r.channel = chan;
    if (enabled[c]) begin
      if (round == '0) latched[c] = 1'b0;
      accum[c] = accum[c] + ACC_W'(weight[c]) * ACC_W'(s);
      if (accum[c] > quantum) begin
        units[c]       = units[c] + 1'b1;
        accum[c]       = accum[c] - quantum;
        open_pulses[c] = open_pulses[c] + 1'b1;
        r.pulse        = 1'b1;
      end
      if (round == period && !latched[c]) begin
        prev_mark[c]     = last_mark[c];
        last_mark[c]     = accum[c];
        closed_pulses[c] = open_pulses[c];
        open_pulses[c]   = '0;
        latched[c]       = 1'b1;
        r.power_valid    = 1'b1;
        r.power_watts    = window_watts(c);
      end
    end
    r.energy_count = units[c];
    chan = (chan == CH_LAST) ? '0 : chan + 1'b1;
    if (chan == '0) round = round + 1'b1;
    if (round > period) round = '0;
    return r;
  endfunction

  always @(posedge clk) begin
    meter_result_t want;
    meter_result_t got;
    if (!rst_n) begin
      for (int c = 0; c < NUM_CH; c++) begin
        weight[c]        = '0;
        accum[c]         = '0;
        units[c]         = '0;
        open_pulses[c]   = '0;
        closed_pulses[c] = '0;
        prev_mark[c]     = '0;
        last_mark[c]     = '0;
        latched[c]       = 1'b0;
      end
      enabled = '0;
      quantum = QUANTUM_RST;
      period  = PERIOD_RST;
      chan    = '0;
      round   = '0;
      predicted_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_MCONST0: weight[0] = cfg_wdata[CONST_W-1:0];
          CFG_MCONST1: weight[1] = cfg_wdata[CONST_W-1:0];
          CFG_MCONST2: weight[2] = cfg_wdata[CONST_W-1:0];
          CFG_ENABLE:  enabled   = cfg_wdata[NUM_CH-1:0];
          CFG_QUANTUM: quantum   = cfg_wdata;
          CFG_PERIOD:  period    = cfg_wdata[ROUND_W-1:0];
          default: ;
        endcase
      end

      // Compare before queueing: an item accepted on this edge cannot have
      // produced the result leaving on the same edge.
      if (out_tvalid && out_tready) begin
        got.channel      = out_tdata[1:0];
        got.pulse        = out_tdata[2];
        got.energy_count = out_tdata[34:3];
        got.power_watts  = out_tdata[55:35];
        got.power_valid  = out_tuser;
        seen++;
        if (got.power_valid) window_count++;
        if (got.pulse) pulse_total++;
        if (predicted_results.size() == 0) begin
          bad_items++;
          if (bad_items <= 10)
            $display("%0t: result item with no sample outstanding: ch=%0d count=%0d",
                     $time, got.channel, got.energy_count);
        end else begin
          want = predicted_results.pop_front();
          if (got.channel != want.channel || got.pulse != want.pulse ||
              got.energy_count != want.energy_count ||
              got.power_valid != want.power_valid ||
              got.power_watts != want.power_watts) begin
            bad_items++;
            if (bad_items <= 10) begin
              $display("%0t: result mismatch", $time);
              $display("  expected ch=%0d pulse=%0b count=%0d power_valid=%0b power=%0d",
                       want.channel, want.pulse, want.energy_count, want.power_valid,
                       $signed(want.power_watts));
              $display("  actual   ch=%0d pulse=%0b count=%0d power_valid=%0b power=%0d",
                       got.channel, got.pulse, got.energy_count, got.power_valid,
                       $signed(got.power_watts));
            end
          end
        end
      end

      if (in_tvalid && in_tready)
        predicted_results.push_back(apply_sample(in_tdata[SAMPLE_BITS-1:0]));
    end
    errors  <= bad_items;
    pending <= predicted_results.size();
    checked <= seen;
    windows <= window_count;
    pulses  <= pulse_total;
  end

endmodule

FILE: sim/energy_meter_accumulator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Energy meter accumulator testbench
// Feeds ADC sample items under a series of register settings, with random
// gaps on the sample side and random stalls on the result side, and leaves
// all checking to the result checker beside the block.
// ----------------------------------------------------------------------------
module energy_meter_accumulator_test;
  import emacc_pkg::*;

  // Index 6 has no register behind it; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 3'd6;

  localparam int ITEM_GOAL   = 450;
  // The slowest item is one that closes a power window.
  localparam int TAIL_CYCLES = 120;
  // Settling time after the last result before a register write.
  localparam int QUIET_CYCLES = 4;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [15:0]           in_tdata   = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [ACC_W-1:0]      cfg_wdata  = '0;

  int errors;
  int pending;
  int checked;
  int windows;
  int pulses;

  int samples_sent = 0;
  int phases       = 0;
  // While set, neither side inserts gaps or stalls.
  bit steady       = 1'b0;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  energy_meter_accumulator DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  energy_meter_accumulator_check result_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .errors     (errors),
    .pending    (pending),
    .checked    (checked),
    .windows    (windows),
    .pulses     (pulses)
  );

  // Offers one sample item after a random gap and returns on the edge that
  // accepts it. The valid stays high, so the next call can follow without a
  // gap.
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 8);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(16 - SAMPLE_BITS){1'b0}}, s};
    do @(posedge clk); while (!in_tready);
    samples_sent++;
  endtask

  // Stops offering samples and waits until every predicted result has come
  // out, so that the block is idle and registers may be written.
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  // A write holds the enable high for one edge and returns with it low again.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ACC_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [ACC_W-1:0] pick_weight();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return 32'd65535;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  // Quanta are mostly small enough that pulses show up within a few samples;
  // the extremes make every sum above one pulse or let the accumulator wrap.
  function automatic logic [ACC_W-1:0] pick_quantum();
    logic [ACC_W-1:0] q;
    case ($urandom_range(0, 5))
      0:       q = 32'd1;
      1:       q = 32'hFFFF_FFFF;
      2:       q = $urandom_range(1, 1 << 22);
      3:       q = $urandom;
      default: q = $urandom_range(1, 1 << 26);
    endcase
    return (q == '0) ? 32'd1 : q;
  endfunction

  // Short periods close many windows within the run; the longest one never
  // closes a window here but exercises the round compare at full width.
  function automatic logic [ACC_W-1:0] pick_period();
    case ($urandom_range(0, 7))
      0:       return 32'd65535;
      1:       return $urandom_range(1, 65535);
      2, 3:    return $urandom_range(4, 20);
      default: return $urandom_range(1, 3);
    endcase
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return $urandom_range(0, (1 << SAMPLE_BITS) - 1);
    endcase
  endfunction

  // Rewrites a random subset of the registers. A period lower than the
  // current round is allowed on purpose: the round counter must wrap.
  task automatic random_settings();
    logic [ACC_W-1:0] mask;
    for (int i = 0; i < NUM_CH; i++)
      if ($urandom_range(0, 2) != 0)
        write_reg(CFG_IDX_W'(CFG_MCONST0 + i), pick_weight());
    if ($urandom_range(0, 1) != 0) begin
      mask = $urandom_range(0, 7);
      // An all-off mask is kept rare; it only yields results without pulses or power.
      if (mask == '0 && $urandom_range(0, 2) != 0) mask = 32'd7;
      write_reg(CFG_ENABLE, mask);
    end
    if ($urandom_range(0, 1) != 0) write_reg(CFG_QUANTUM, pick_quantum());
    if ($urandom_range(0, 1) != 0) write_reg(CFG_PERIOD, pick_period());
    if ($urandom_range(0, 9) == 0) write_reg(CFG_SPARE, $urandom);
  endtask

  initial begin : result_sink
    int stall;
    do @(posedge clk); while (!rst_n);
    forever begin
      stall = steady ? 0 : $urandom_range(0, 8);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!(out_tvalid && out_tready));
    end
  end

  initial begin : stimulus
    logic [SAMPLE_BITS-1:0] first_run [9];
    logic [SAMPLE_BITS-1:0] second_run[12];
    int                     count;

    first_run  = '{10'd1023, 10'd0, 10'd1023, 10'h155, 10'h2AA, 10'd1,
                   10'd1023, 10'd1023, 10'd1023};
    second_run = '{10'd1023, 10'd1023, 10'd1023, 10'd512, 10'd0, 10'd1023,
                   10'h2AA, 10'h155, 10'd1023, 10'd1023, 10'd1023, 10'd1023};

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // With the reset settings every channel is off: results carry the
    // channel number and nothing else.
    steady = 1'b1;
    repeat (3) send_sample(10'd1023);
    drain();
    phases++;

    // Full-scale weight on channel 0, the smallest nonzero one on channel 1,
    // channel 2 off. A quantum of one makes every sum above one pulse, and a
    // period of one closes a window on every enabled channel each second round.
    write_reg(CFG_MCONST0, 32'd65535);
    write_reg(CFG_MCONST1, 32'd1);
    write_reg(CFG_MCONST2, 32'd40000);
    write_reg(CFG_ENABLE,  32'd3);
    write_reg(CFG_QUANTUM, 32'd1);
    write_reg(CFG_PERIOD,  32'd1);
    steady = 1'b0;
    foreach (first_run[i]) send_sample(first_run[i]);
    drain();
    phases++;

    // All channels on, the largest quantum (no pulses, only accumulation),
    // a period of two, and a write to the index with no register.
    write_reg(CFG_MCONST2, 32'd65535);
    write_reg(CFG_ENABLE,  32'd7);
    write_reg(CFG_QUANTUM, 32'hFFFF_FFFF);
    write_reg(CFG_PERIOD,  32'd2);
    write_reg(CFG_SPARE,   32'hFFFF_FFFF);
    foreach (second_run[i]) send_sample(second_run[i]);

    // Random phases: new settings, then a burst of random samples. About
    // one phase in four runs without gaps or stalls.
    while (samples_sent < ITEM_GOAL) begin
      drain();
      phases++;
      random_settings();
      steady = ($urandom_range(0, 3) == 0);
      count  = $urandom_range(15, 45);
      repeat (count) send_sample(pick_sample());
    end
    drain();
    steady = 1'b0;
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Sent %0d samples over %0d register settings; checked %0d results.",
             samples_sent, phases, checked);
    $display("The results held %0d energy pulses and %0d closed power windows.",
             pulses, windows);
    if (errors == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Far beyond the slowest correct run of about 500 items, plus register
  // writes and drain pauses.
  initial begin : watchdog
    #5_000_000;
    $display("Run did not finish in time; %0d results still outstanding.", pending);
    $display("FAILED: results differ");
    $finish;
  end

endmodule
